FILE: hdl/qpr_pkg.sv
// Shared constants and types for the quaternion point rotation block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package qpr_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUAT_WIDTH_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 2;

    // Cycles the input stays closed after reset or a register write while the
    // rotation matrix is recomputed.
    localparam int SETTLE_WIDTH = 2;
    localparam logic [SETTLE_WIDTH-1:0] SETTLE_CYCLES = 2'd3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_I = 2'd1,
        REG_QUAT_J = 2'd2,
        REG_QUAT_K = 2'd3
    } cfg_index_t;

endpackage

FILE: hdl/qpr_in_if.sv
// Input channel of the quaternion point rotation block: one point per item.
// Depends on qpr_pkg for the default coordinate width.
interface qpr_in_if #(
    parameter int COORD_WIDTH = qpr_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] px_in;
    logic signed [COORD_WIDTH-1:0] py_in;
    logic signed [COORD_WIDTH-1:0] pz_in;
    logic                          last_in;

    modport source (
        output valid,
        output px_in,
        output py_in,
        output pz_in,
        output last_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  px_in,
        input  py_in,
        input  pz_in,
        input  last_in,
        output ready
    );
endinterface

FILE: hdl/qpr_out_if.sv
// Output channel of the quaternion point rotation block: one rotated point per item.
// Depends on qpr_pkg for the default coordinate width.
interface qpr_out_if #(
    parameter int COORD_WIDTH = qpr_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] px_out;
    logic signed [COORD_WIDTH-1:0] py_out;
    logic signed [COORD_WIDTH-1:0] pz_out;
    logic                          last_out;
    logic                          zero_quat;
    logic                          saturated;

    modport source (
        output valid,
        output px_out,
        output py_out,
        output pz_out,
        output last_out,
        output zero_quat,
        output saturated,
        input  ready
    );

    modport sink (
        input  valid,
        input  px_out,
        input  py_out,
        input  pz_out,
        input  last_out,
        input  zero_quat,
        input  saturated,
        output ready
    );
endinterface

FILE: hdl/qpr_matrix.sv
// Two-stage pipeline that forms the nine rotation-matrix numerators and the
// squared norm from the quaternion registers. Depends on qpr_pkg for the default width.
module qpr_matrix #(
    parameter int QUAT_WIDTH = qpr_pkg::QUAT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic signed [QUAT_WIDTH-1:0]   quat_w,
    input  logic signed [QUAT_WIDTH-1:0]   quat_i,
    input  logic signed [QUAT_WIDTH-1:0]   quat_j,
    input  logic signed [QUAT_WIDTH-1:0]   quat_k,
    output logic signed [2*QUAT_WIDTH+1:0] mat [9],
    output logic [2*QUAT_WIDTH:0]          norm,
    output logic                           zero
);
    localparam int PW = 2 * QUAT_WIDTH;
    localparam int MW = 2 * QUAT_WIDTH + 2;
    localparam int SW = 2 * QUAT_WIDTH + 1;

    logic signed [PW-1:0] ww_reg, ii_reg, jj_reg, kk_reg;
    logic signed [PW-1:0] ij_reg, wk_reg, ik_reg, wj_reg, jk_reg, wi_reg;
    logic signed [MW-1:0] mat_reg [9];
    logic signed [MW-1:0] mat_next [9];
    logic [SW-1:0]        norm_reg, norm_next;
    logic                 zero_reg;

    always_ff @(posedge clk)
    begin
        ww_reg <= PW'(quat_w) * PW'(quat_w);
        ii_reg <= PW'(quat_i) * PW'(quat_i);
        jj_reg <= PW'(quat_j) * PW'(quat_j);
        kk_reg <= PW'(quat_k) * PW'(quat_k);
        ij_reg <= PW'(quat_i) * PW'(quat_j);
        wk_reg <= PW'(quat_w) * PW'(quat_k);
        ik_reg <= PW'(quat_i) * PW'(quat_k);
        wj_reg <= PW'(quat_w) * PW'(quat_j);
        jk_reg <= PW'(quat_j) * PW'(quat_k);
        wi_reg <= PW'(quat_w) * PW'(quat_i);
    end

    always_comb
    begin
        mat_next[0] = MW'(ww_reg) + MW'(ii_reg) - MW'(jj_reg) - MW'(kk_reg);
        mat_next[1] = (MW'(ij_reg) + MW'(wk_reg)) <<< 1;
        mat_next[2] = (MW'(ik_reg) - MW'(wj_reg)) <<< 1;
        mat_next[3] = (MW'(ij_reg) - MW'(wk_reg)) <<< 1;
        mat_next[4] = MW'(ww_reg) - MW'(ii_reg) + MW'(jj_reg) - MW'(kk_reg);
        mat_next[5] = (MW'(jk_reg) + MW'(wi_reg)) <<< 1;
        mat_next[6] = (MW'(ik_reg) + MW'(wj_reg)) <<< 1;
        mat_next[7] = (MW'(jk_reg) - MW'(wi_reg)) <<< 1;
        mat_next[8] = MW'(ww_reg) - MW'(ii_reg) - MW'(jj_reg) + MW'(kk_reg);
        norm_next = $unsigned(SW'(ww_reg) + SW'(ii_reg) + SW'(jj_reg) + SW'(kk_reg));
    end

    always_ff @(posedge clk)
    begin
        mat_reg  <= mat_next;
        norm_reg <= norm_next;
        zero_reg <= (norm_next == '0);
    end

    assign mat  = mat_reg;
    assign norm = norm_reg;
    assign zero = zero_reg;
endmodule

FILE: hdl/qpr_divider.sv
// Pipelined restoring divider that rounds a row sum divided by the squared norm
// half away from zero and saturates it to the coordinate width. Depends on qpr_pkg.
module qpr_divider #(
    parameter int COORD_WIDTH = qpr_pkg::COORD_WIDTH_DEF,
    parameter int QUAT_WIDTH  = qpr_pkg::QUAT_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic signed [2*QUAT_WIDTH+COORD_WIDTH+3:0] num,
    input  logic [2*QUAT_WIDTH:0]                     norm,
    output logic signed [COORD_WIDTH-1:0]             coord,
    output logic                                      sat
);
    localparam int SW = 2 * QUAT_WIDTH + 1;
    localparam int NW = 2 * QUAT_WIDTH + COORD_WIDTH + 4;
    localparam int QB = COORD_WIDTH + 2;
    localparam int RW = SW + 1 + QB;
    localparam int DW = RW + 1;

    logic [RW-1:0] rem_reg [QB];
    logic [RW-1:0] rem_next [QB];
    logic [QB-1:0] quo_reg [QB+1];
    logic [QB-1:0] quo_next [QB+1];
    logic          neg_reg [QB+1];
    logic [DW-1:0] diff [QB];

    logic [NW-1:0] mag;
    logic [SW:0]   dbl;

    logic [QB-1:0]                 limit;
    logic                          over;
    logic [COORD_WIDTH-1:0]        val;
    logic signed [COORD_WIDTH-1:0] coord_reg, coord_next;
    logic                          sat_reg;

    assign dbl = {norm, 1'b0};

    // The dividend is 2*|num| + s and the divisor 2*s, so the floor of the
    // quotient is the magnitude rounded half away from zero.
    always_comb
    begin
        mag = num[NW-1] ? -num : num;
        rem_next[0] = {mag[RW-2:0], 1'b0} + RW'(norm);
        quo_next[0] = '0;
        for (int k = 1; k <= QB; k++)
        begin
            diff[k-1] = {1'b0, rem_reg[k-1]} - (DW'(dbl) << (QB - k));
            quo_next[k] = quo_reg[k-1];
            quo_next[k][QB-k] = !diff[k-1][RW];
        end
        for (int k = 1; k < QB; k++)
            rem_next[k] = diff[k-1][RW] ? rem_reg[k-1] : diff[k-1][RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
            neg_reg[0] <= num[NW-1];
            for (int k = 1; k <= QB; k++)
                neg_reg[k] <= neg_reg[k-1];
        end
    end

    always_comb
    begin
        limit = (QB'(1) << (COORD_WIDTH - 1)) - QB'(!neg_reg[QB]);
        over = (quo_reg[QB] > limit);
        val = over ? limit[COORD_WIDTH-1:0] : quo_reg[QB][COORD_WIDTH-1:0];
        coord_next = neg_reg[QB] ? -$signed(val) : $signed(val);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coord_reg <= coord_next;
            sat_reg   <= over;
        end
    end

    assign coord = coord_reg;
    assign sat   = sat_reg;
endmodule

FILE: hdl/quaternion_point_rotation.sv
// Throughput: one point per cycle through COORD_WIDTH + 2 one-bit divider stages; a stalled
// output parks one item in a skid register, and the pipeline and input halt while it is full.
// Reset loads the identity quaternion (w = 1) and empties the pipeline; the input
// stays closed after reset or any register write while the matrix settles.
// Depends on qpr_pkg, qpr_in_if, qpr_out_if, qpr_matrix and qpr_divider.
module quaternion_point_rotation #(
    parameter int COORD_WIDTH = qpr_pkg::COORD_WIDTH_DEF,
    parameter int QUAT_WIDTH  = qpr_pkg::QUAT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    qpr_in_if.sink                               point,
    qpr_out_if.source                            result,
    input  logic                                 wr_en,
    input  logic [qpr_pkg::CFG_INDEX_WIDTH-1:0]  wr_index,
    input  logic [QUAT_WIDTH-1:0]                wr_data
);
    localparam int MW  = 2 * QUAT_WIDTH + 2;
    localparam int SW  = 2 * QUAT_WIDTH + 1;
    localparam int PRW = MW + COORD_WIDTH;
    localparam int NW  = 2 * QUAT_WIDTH + COORD_WIDTH + 4;
    localparam int QB  = COORD_WIDTH + 2;
    localparam int NST = QB + 5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] pz;
        logic                          last;
        logic                          zero;
        logic                          sat;
    } res_t;

    logic signed [QUAT_WIDTH-1:0] quat_w_reg, quat_i_reg, quat_j_reg, quat_k_reg;
    logic [qpr_pkg::SETTLE_WIDTH-1:0] settle_reg, settle_next;

    logic signed [MW-1:0] mat [9];
    logic [SW-1:0]        norm;
    logic                 zero;

    logic                          en;
    logic                          accept;
    logic                          vld_reg [NST];
    logic                          last_reg [NST];
    logic signed [COORD_WIDTH-1:0] p_reg [3];
    logic signed [PRW-1:0]         prod_reg [9];
    logic signed [NW-1:0]          acc_reg [3];
    logic signed [COORD_WIDTH-1:0] coord [3];
    logic                          sat [3];

    res_t fin;
    res_t out_reg, skid_reg;
    logic out_vld_reg, skid_vld_reg;

    // Configuration registers and the settle counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_w_reg <= QUAT_WIDTH'(1);
            quat_i_reg <= '0;
            quat_j_reg <= '0;
            quat_k_reg <= '0;
        end
        else if (wr_en)
        begin
            case (qpr_pkg::cfg_index_t'(wr_index))
                qpr_pkg::REG_QUAT_W: quat_w_reg <= wr_data;
                qpr_pkg::REG_QUAT_I: quat_i_reg <= wr_data;
                qpr_pkg::REG_QUAT_J: quat_j_reg <= wr_data;
                qpr_pkg::REG_QUAT_K: quat_k_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (wr_en)
            settle_next = qpr_pkg::SETTLE_CYCLES;
        else if (settle_reg != '0)
            settle_next = settle_reg - 1'b1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= qpr_pkg::SETTLE_CYCLES;
        else
            settle_reg <= settle_next;
    end

    qpr_matrix #(
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_matrix (
        .clk    (clk),
        .quat_w (quat_w_reg),
        .quat_i (quat_i_reg),
        .quat_j (quat_j_reg),
        .quat_k (quat_k_reg),
        .mat    (mat),
        .norm   (norm),
        .zero   (zero)
    );

    // The point pipeline and the dividers move together unless the skid register is occupied.
    assign en = !skid_vld_reg;
    assign point.ready = en && (settle_reg == '0);
    assign accept = point.valid && point.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NST; n++)
                vld_reg[n] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= accept;
            for (int n = 1; n < NST; n++)
                vld_reg[n] <= vld_reg[n-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg[0] <= point.last_in;
            for (int n = 1; n < NST; n++)
                last_reg[n] <= last_reg[n-1];
            p_reg[0] <= point.px_in;
            p_reg[1] <= point.py_in;
            p_reg[2] <= point.pz_in;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r*3+c] <= PRW'(mat[r*3+c]) * PRW'(p_reg[c]);
            end
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= NW'(prod_reg[r*3]) + NW'(prod_reg[r*3+1])
                              + NW'(prod_reg[r*3+2]);
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        qpr_divider #(
            .COORD_WIDTH (COORD_WIDTH),
            .QUAT_WIDTH  (QUAT_WIDTH)
        ) u_divider (
            .clk   (clk),
            .en    (en),
            .num   (acc_reg[r]),
            .norm  (norm),
            .coord (coord[r]),
            .sat   (sat[r])
        );
    end

    always_comb
    begin
        fin.px   = zero ? '0 : coord[0];
        fin.py   = zero ? '0 : coord[1];
        fin.pz   = zero ? '0 : coord[2];
        fin.last = last_reg[NST-1];
        fin.zero = zero;
        fin.sat  = !zero && (sat[0] || sat[1] || sat[2]);
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (result.ready)
                skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || result.ready)
        begin
            out_vld_reg <= vld_reg[NST-1];
        end
        else if (vld_reg[NST-1])
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (result.ready)
                out_reg <= skid_reg;
        end
        else if (!out_vld_reg || result.ready)
        begin
            out_reg <= fin;
        end
        else
        begin
            skid_reg <= fin;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.px_out    = out_reg.px;
    assign result.py_out    = out_reg.py;
    assign result.pz_out    = out_reg.pz;
    assign result.last_out  = out_reg.last;
    assign result.zero_quat = out_reg.zero;
    assign result.saturated = out_reg.sat;
endmodule
